>>> src/sud_pkg.sv
// Shared types, widths and constants for the decimal scale-up divider.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sud_pkg;

    localparam int WORD_W        = 64;
    localparam int NUM_W         = 256;   // scaled dividend magnitude
    localparam int DEN_W         = 128;   // divisor magnitude / remainder
    localparam int SCALE_W       = 7;
    localparam int DEF_MAX_SCALE  = 76;
    localparam int DEF_MAX_DIGITS = 38;

    // Beat moving along the times-ten chain.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
    } t_scl_beat;

    // Beat moving along the divide chain; word holds dividend bits on top,
    // quotient bits shift in from the bottom.
    typedef struct packed {
        logic [NUM_W-1:0] word;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
    } t_div_beat;

    // 10^n in 128 bits, elaboration time only.
    function automatic logic [DEN_W-1:0] f_pow10(input int n);
        logic [DEN_W-1:0] v;
        v = DEN_W'(1);
        for (int k = 0; k < n; k++) begin
            v = (v << 3) + (v << 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/sud_mul10_cell.sv
// One cell of the times-ten chain: multiplies by ten when its index is
// below the scale, flags a carry out of 256 bits. Depends on sud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sud_mul10_cell #(
    parameter int IDX = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic [sud_pkg::SCALE_W-1:0] i_scale,
    input  wire logic                    i_valid,
    input  wire sud_pkg::t_scl_beat      i_beat,
    output logic                         o_valid,
    output sud_pkg::t_scl_beat           o_beat
);
    import sud_pkg::*;

    logic [NUM_W+3:0] w_prod;
    t_scl_beat        n_beat;
    logic             r_valid;
    t_scl_beat        r_beat;

    assign w_prod = ({4'b0, i_beat.num} << 3) + ({4'b0, i_beat.num} << 1);

    always_comb begin
        n_beat = i_beat;
        if (!i_beat.ovf && (SCALE_W'(IDX) < i_scale)) begin
            if (w_prod[NUM_W+3:NUM_W] != 4'b0) begin
                n_beat.ovf = 1'b1;
            end else begin
                n_beat.num = w_prod[NUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

>>> src/sud_div_cell.sv
// One restoring-division step: shifts in the next dividend bit, subtracts
// the divisor when it fits, shifts the quotient bit in. Depends on sud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sud_div_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire sud_pkg::t_div_beat i_beat,
    output logic                    o_valid,
    output sud_pkg::t_div_beat      o_beat
);
    import sud_pkg::*;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W+1:0] w_diff;
    logic             w_fit;
    t_div_beat        n_beat;
    logic             r_valid;
    t_div_beat        r_beat;

    assign w_trial = {i_beat.rem, i_beat.word[NUM_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b0, i_beat.den};
    assign w_fit   = !w_diff[DEN_W+1];

    always_comb begin
        n_beat      = i_beat;
        n_beat.word = {i_beat.word[NUM_W-2:0], w_fit};
        n_beat.rem  = w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

>>> src/decimal_scale_up_divide.sv
// Top level of the decimal scale-up divider: input stage, times-ten chain,
// divide chain, rounding, range check and output skid. Depends on sud_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Signed 128-bit decimal divide with round half away from zero. The dividend
// magnitude is scaled by 10^scale_up (held in a 256-bit word), divided by the
// divisor magnitude, rounded, range checked against 10^MAX_DIGITS-1 and
// given the sign of the operands. One beat is taken every clock cycle while
// the output buffer has room; each beat passes one input stage, MAX_SCALE times-ten
// cells, 256 restoring-division cells, a rounding stage and a range/sign
// stage before the output register. The whole chain moves together and
// stops only when the two-entry output buffer is full. A zero divisor,
// scale_up above MAX_SCALE, a scaled dividend of 2^256 or more, or an
// out-of-range quotient set overflowed and force the quotient to zero.
// scale_up is taken from the config register while items flow, so write it
// only when the block is empty.
module decimal_scale_up_divide #(
    parameter int MAX_SCALE  = sud_pkg::DEF_MAX_SCALE,
    parameter int MAX_DIGITS = sud_pkg::DEF_MAX_DIGITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sud_pkg::SCALE_W-1:0]       i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [sud_pkg::WORD_W-1:0] i_dividend_high,
    input  wire logic [sud_pkg::WORD_W-1:0]        i_dividend_low,
    input  wire logic signed [sud_pkg::WORD_W-1:0] i_divisor_high,
    input  wire logic [sud_pkg::WORD_W-1:0]        i_divisor_low,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [sud_pkg::WORD_W-1:0]      o_quotient_high,
    output logic [sud_pkg::WORD_W-1:0]             o_quotient_low,
    output logic                                   o_overflowed
);
    import sud_pkg::*;

    localparam logic [DEN_W-1:0] LIMIT = f_pow10(MAX_DIGITS);

    // config
    logic [SCALE_W-1:0] r_scale;

    // global advance: the chain moves while the skid slot is free
    logic w_en;

    // input stage
    logic [DEN_W-1:0] w_x, w_y;
    logic             r_s0_valid;
    t_scl_beat        r_s0;

    // chains
    logic      w_scl_v [0:MAX_SCALE];
    t_scl_beat w_scl   [0:MAX_SCALE];
    logic      w_div_v [0:NUM_W];
    t_div_beat w_div   [0:NUM_W];

    // rounding stage
    logic             r_rnd_valid;
    logic [NUM_W-1:0] r_rnd_q;
    logic             r_rnd_neg;
    logic             r_rnd_ovf;
    logic [DEN_W:0]   w_twice;
    logic             w_up;
    logic [NUM_W:0]   w_inc;

    // range / sign stage
    logic             w_fin_ovf;
    logic [DEN_W-1:0] w_fin_q;
    logic             r_fin_valid;
    logic [DEN_W:0]   r_fin;        // {ovf, quotient}

    // output buffer
    logic             w_push, w_pop;
    logic             r_out_valid, r_skid_valid;
    logic [DEN_W:0]   r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // magnitudes of the operands
    assign w_x = i_dividend_high[WORD_W-1] ? (~{i_dividend_high, i_dividend_low} + DEN_W'(1))
                                           : {i_dividend_high, i_dividend_low};
    assign w_y = i_divisor_high[WORD_W-1] ? (~{i_divisor_high, i_divisor_low} + DEN_W'(1))
                                          : {i_divisor_high, i_divisor_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0.num <= {{(NUM_W-DEN_W){1'b0}}, w_x};
            r_s0.den <= w_y;
            r_s0.neg <= i_dividend_high[WORD_W-1] ^ i_divisor_high[WORD_W-1];
            r_s0.ovf <= ({i_divisor_high, i_divisor_low} == '0)
                        || (r_scale > SCALE_W'(MAX_SCALE));
        end
    end

    assign w_scl_v[0] = r_s0_valid;
    assign w_scl[0]   = r_s0;

    for (genvar k = 0; k < MAX_SCALE; k++) begin : g_scl
        sud_mul10_cell #(.IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_scale (r_scale),
            .i_valid (w_scl_v[k]),
            .i_beat  (w_scl[k]),
            .o_valid (w_scl_v[k+1]),
            .o_beat  (w_scl[k+1])
        );
    end

    assign w_div_v[0]   = w_scl_v[MAX_SCALE];
    assign w_div[0].word = w_scl[MAX_SCALE].num;
    assign w_div[0].rem  = '0;
    assign w_div[0].den  = w_scl[MAX_SCALE].den;
    assign w_div[0].neg  = w_scl[MAX_SCALE].neg;
    assign w_div[0].ovf  = w_scl[MAX_SCALE].ovf;

    for (genvar b = 0; b < NUM_W; b++) begin : g_div
        sud_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_div_v[b]),
            .i_beat  (w_div[b]),
            .o_valid (w_div_v[b+1]),
            .o_beat  (w_div[b+1])
        );
    end

    // round half away from zero: bump magnitude when 2*rem >= den
    assign w_twice = {w_div[NUM_W].rem, 1'b0};
    assign w_up    = w_twice >= {1'b0, w_div[NUM_W].den};
    assign w_inc   = {1'b0, w_div[NUM_W].word} + (NUM_W+1)'(w_up);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_valid <= 1'b0;
        end else if (w_en) begin
            r_rnd_valid <= w_div_v[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rnd_q   <= w_inc[NUM_W-1:0];
            r_rnd_neg <= w_div[NUM_W].neg;
            r_rnd_ovf <= w_div[NUM_W].ovf || w_inc[NUM_W];
        end
    end

    // range check, then sign
    assign w_fin_ovf = r_rnd_ovf || (r_rnd_q[NUM_W-1:DEN_W] != '0)
                       || (r_rnd_q[DEN_W-1:0] >= LIMIT);
    assign w_fin_q   = w_fin_ovf ? '0
                     : (r_rnd_neg ? (~r_rnd_q[DEN_W-1:0] + DEN_W'(1)) : r_rnd_q[DEN_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_en) begin
            r_fin_valid <= r_rnd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= {w_fin_ovf, w_fin_q};
        end
    end

    // two-entry output buffer: the chain keeps moving while one result waits
    assign w_push = w_en && r_fin_valid;
    assign w_pop  = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= r_fin;
            end else begin
                r_skid <= r_fin;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_overflowed    = r_out[DEN_W];
    assign o_quotient_high = r_out[DEN_W-1:WORD_W];
    assign o_quotient_low  = r_out[WORD_W-1:0];

endmodule

`default_nettype wire

>>> src/sud_checker.sv
// Port-level checks for decimal_scale_up_divide, bound to the top level.
// Depends on sud_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module sud_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_in_ready,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [sud_pkg::WORD_W-1:0] o_quotient_high,
    input wire logic [sud_pkg::WORD_W-1:0]        o_quotient_low,
    input wire logic                              o_overflowed
);
    import sud_pkg::*;

    // overflow forces a zero quotient
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflowed) |-> (o_quotient_high == '0 && o_quotient_low == '0))
        else $error("overflow beat with nonzero quotient");

    // input backs off only when a result is waiting
    a_ready_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_quotient_high)
            && $stable(o_quotient_low) && $stable(o_overflowed)))
        else $error("stalled result beat changed");

endmodule

bind decimal_scale_up_divide sud_checker u_sud_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_quotient_high (o_quotient_high),
    .o_quotient_low  (o_quotient_low),
    .o_overflowed    (o_overflowed)
);

`default_nettype wire
